@@ rtl/cmdsplit_pkg.sv @@
`default_nettype none

package cmdsplit_pkg;

  // Default widths of the saturating backslash run and argument counters
  localparam int RUN_BITS_DEF   = 16;
  localparam int COUNT_BITS_DEF = 16;

  // Result queue geometry (depth must be a power of two, at least 2)
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QLVL_W = $clog2(QDEPTH + 1);

  // Characters the splitter reacts to
  localparam logic [15:0] CH_NUL    = 16'h0000;
  localparam logic [15:0] CH_QUOTE  = 16'h0022;
  localparam logic [15:0] CH_BSLASH = 16'h005C;
  localparam logic [15:0] CH_SPACE  = 16'h0020;
  localparam logic [15:0] CH_TAB    = 16'h0009;

  // Quote level at which a quote inside a quote run wraps the level back to zero
  localparam logic [1:0] QUOTE_THIRD = 2'd3;

  typedef enum logic [1:0] {
    KIND_BSLASH   = 2'd0,
    KIND_CHAR     = 2'd1,
    KIND_ARG_END  = 2'd2,
    KIND_LINE_END = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_EXEQ  = 3'd1,
    PH_EXEP  = 3'd2,
    PH_SKIP  = 3'd3,
    PH_ARG   = 3'd4
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] ch;
    logic [15:0] prefix;
    logic [15:0] total;
    logic        last;
  } result_t;

  // Up to two results written into the queue in one cycle
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

`default_nettype wire

@@ rtl/command_line_argument_splitter_unit.sv @@
`default_nettype none

// Splits a command line of 16-bit code units into arguments, one code unit
// per input word, with code 0 ending the line. Each word yields zero, one or
// two result words (character, argument end, line end, or a bare run of
// backslashes), each carrying the literal backslashes to put in front of it
// and the running argument count. A word is registered on input and passes
// through the splitter state update into a four-entry result queue; the next
// word follows in the very next cycle as long as the queue has room for two
// results, so the sustained rate is one word per cycle when results are
// drained every cycle. A line end that closes an open argument delivers both
// an argument end and a line end. The first result of a word passes through
// the input register and the result queue before it becomes visible.
module command_line_argument_splitter_unit #(
  parameter int RUN_BITS   = cmdsplit_pkg::RUN_BITS_DEF,
  parameter int COUNT_BITS = cmdsplit_pkg::COUNT_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] in_char_code,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_kind,
  output logic [15:0]      out_out_char,
  output logic [15:0]      out_backslash_prefix,
  output logic [15:0]      out_arg_total,
  output logic             out_last_of_run
);

  logic                                in_valid_r, in_valid_nxt;
  logic [15:0]                         in_char_r;
  logic                                adv;
  logic                                pop;
  logic                                room;
  logic [cmdsplit_pkg::QLVL_W-1:0]     q_level;
  logic [cmdsplit_pkg::QLVL_W-1:0]     q_free;
  cmdsplit_pkg::push_t                 push;
  cmdsplit_pkg::result_t               q_head;

  // Advance the held word once the queue can take both of its results,
  // counting the slot freed by a result leaving this cycle.
  always_comb begin
    pop          = out_valid && out_ready;
    q_free       = cmdsplit_pkg::QLVL_W'(cmdsplit_pkg::QDEPTH) - q_level;
    room         = cmdsplit_pkg::QLVL_W'(q_free + cmdsplit_pkg::QLVL_W'(pop))
                   >= cmdsplit_pkg::QLVL_W'(2);
    adv          = in_valid_r && room;
    in_ready     = !in_valid_r || adv;
    in_valid_nxt = in_ready ? in_valid : in_valid_r;
  end

  // Input register: hold the word until the splitter takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_char_r <= in_char_code;
  end

  cmdsplit_core #(
    .RUN_BITS   (RUN_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .char_code (in_char_r),
    .push      (push)
  );

  cmdsplit_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop_ready  (out_ready),
    .head       (q_head),
    .head_valid (out_valid),
    .level      (q_level)
  );

  // Drive result ports straight from the queue head
  assign out_kind             = q_head.kind;
  assign out_out_char         = q_head.ch;
  assign out_backslash_prefix = q_head.prefix;
  assign out_arg_total        = q_head.total;
  assign out_last_of_run      = q_head.last;

  // Queue never holds more results than it has entries
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_level <= cmdsplit_pkg::QLVL_W'(cmdsplit_pkg::QDEPTH))
    else $error("result queue overfilled");

  // A held word that is not advanced stays put
  a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !adv |=> in_valid_r && $stable(in_char_r))
    else $error("held word lost or changed");

  // A double result always closes with a line end
  a_pair_line_end: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt == 2'd2 |-> push.r1.kind == cmdsplit_pkg::KIND_LINE_END)
    else $error("second result is not a line end");

  // Results only ever enter when the splitter advances a word
  a_push_on_adv: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd0 |-> adv)
    else $error("result pushed without a word");

endmodule

`default_nettype wire

@@ rtl/cmdsplit_core.sv @@
`default_nettype none

module cmdsplit_core #(
  parameter int RUN_BITS   = cmdsplit_pkg::RUN_BITS_DEF,
  parameter int COUNT_BITS = cmdsplit_pkg::COUNT_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                adv,
  input  wire logic [15:0]         char_code,
  output cmdsplit_pkg::push_t      push
);

  cmdsplit_pkg::phase_t   phase_r, phase_nxt;
  logic [1:0]             ql_r, ql_nxt;
  logic                   iqr_r, iqr_nxt;
  logic [RUN_BITS-1:0]    run_r, run_nxt;
  logic [COUNT_BITS-1:0]  cnt_r, cnt_nxt;

  logic                   is_z, is_b, is_q, is_s;
  logic                   in_arg, enter;
  logic [1:0]             ql_e, ql1, ql2;
  logic                   iqr_e, iqr1, clr_run;
  logic [RUN_BITS-1:0]    run_e, run_inc, half;
  logic                   inc;
  logic [COUNT_BITS-1:0]  cnt_inc;
  logic [15:0]            run_clip, half_clip, tot_clip;
  logic                   arg_go;
  logic [1:0]             n;
  cmdsplit_pkg::result_t  r0, r1;

  // Shared decode of the current word against the held state
  always_comb begin
    is_z    = (char_code == cmdsplit_pkg::CH_NUL);
    is_b    = (char_code == cmdsplit_pkg::CH_SPACE) || (char_code == cmdsplit_pkg::CH_TAB);
    is_q    = (char_code == cmdsplit_pkg::CH_QUOTE);
    is_s    = (char_code == cmdsplit_pkg::CH_BSLASH);
    in_arg  = (phase_r == cmdsplit_pkg::PH_ARG);
    enter   = (phase_r == cmdsplit_pkg::PH_SKIP) && !is_z && !is_b;
    arg_go  = in_arg || enter;
    // A new argument starts from cleared quote and backslash state
    ql_e    = in_arg ? ql_r  : 2'd0;
    iqr_e   = in_arg ? iqr_r : 1'b0;
    run_e   = in_arg ? run_r : '0;
    clr_run = iqr_e && !is_q;
    ql1     = (clr_run && (ql_e == 2'd2)) ? 2'd0 : ql_e;
    iqr1    = clr_run ? 1'b0 : iqr_e;
    ql2     = ql1 + 2'd1;
    run_inc = (&run_e) ? run_e : run_e + 1'b1;
    half    = run_e >> 1;
    case (phase_r)
      cmdsplit_pkg::PH_EXEQ,
      cmdsplit_pkg::PH_EXEP,
      cmdsplit_pkg::PH_ARG:  inc = 1'b0;
      cmdsplit_pkg::PH_SKIP: inc = enter;
      default:               inc = !is_z;
    endcase
    cnt_inc = (inc && !(&cnt_r)) ? cnt_r + 1'b1 : cnt_r;
  end

  generate
    if (RUN_BITS > 16) begin : g_run_wide
      assign run_clip  = (|run_e[RUN_BITS-1:16]) ? 16'hFFFF : run_e[15:0];
      assign half_clip = (|half[RUN_BITS-1:16])  ? 16'hFFFF : half[15:0];
    end else begin : g_run_narrow
      assign run_clip  = 16'(run_e);
      assign half_clip = 16'(half);
    end
    if (COUNT_BITS > 16) begin : g_cnt_wide
      assign tot_clip = (|cnt_inc[COUNT_BITS-1:16]) ? 16'hFFFF : cnt_inc[15:0];
    end else begin : g_cnt_narrow
      assign tot_clip = 16'(cnt_inc);
    end
  endgenerate

  // Next state
  always_comb begin
    phase_nxt = phase_r;
    ql_nxt    = ql_r;
    iqr_nxt   = iqr_r;
    run_nxt   = run_r;
    cnt_nxt   = cnt_r;
    if (adv) begin
      cnt_nxt = cnt_inc;
      case (phase_r)
        cmdsplit_pkg::PH_EXEQ: begin
          if (is_q) phase_nxt = cmdsplit_pkg::PH_SKIP;
        end
        cmdsplit_pkg::PH_EXEP: begin
          if (is_b) phase_nxt = cmdsplit_pkg::PH_SKIP;
        end
        cmdsplit_pkg::PH_SKIP,
        cmdsplit_pkg::PH_ARG: begin
          if (arg_go) begin
            phase_nxt = cmdsplit_pkg::PH_ARG;
            ql_nxt    = ql1;
            iqr_nxt   = iqr1;
            run_nxt   = run_e;
            if (is_b && (ql1 == 2'd0)) begin
              run_nxt   = '0;
              phase_nxt = cmdsplit_pkg::PH_SKIP;
            end else if (is_s) begin
              run_nxt = run_inc;
            end else if (is_q) begin
              if (iqr1) begin
                ql_nxt = (ql2 == cmdsplit_pkg::QUOTE_THIRD) ? 2'd0 : ql2;
              end else begin
                iqr_nxt = 1'b1;
                run_nxt = '0;
                ql_nxt  = run_e[0] ? ql1 : ql2;
              end
            end else begin
              run_nxt = '0;
            end
          end
        end
        default: begin
          if (is_q) phase_nxt = cmdsplit_pkg::PH_EXEQ;
          else if (is_b) phase_nxt = cmdsplit_pkg::PH_SKIP;
          else phase_nxt = cmdsplit_pkg::PH_EXEP;
        end
      endcase
      // End of line drops everything back to start of line
      if (is_z) begin
        phase_nxt = cmdsplit_pkg::PH_START;
        ql_nxt    = 2'd0;
        iqr_nxt   = 1'b0;
        run_nxt   = '0;
        cnt_nxt   = '0;
      end
    end
  end

  // Results
  always_comb begin
    r0        = '0;
    r1        = '0;
    r0.kind   = cmdsplit_pkg::KIND_BSLASH;
    r1.kind   = cmdsplit_pkg::KIND_LINE_END;
    r0.total  = tot_clip;
    r1.total  = tot_clip;
    n         = 2'd0;
    case (phase_r)
      cmdsplit_pkg::PH_EXEQ,
      cmdsplit_pkg::PH_EXEP: begin
        if (is_z) begin
          r0.kind = cmdsplit_pkg::KIND_ARG_END;
          n       = 2'd2;
        end else if ((phase_r == cmdsplit_pkg::PH_EXEQ) ? is_q : is_b) begin
          r0.kind = cmdsplit_pkg::KIND_ARG_END;
          n       = 2'd1;
        end else begin
          r0.kind = cmdsplit_pkg::KIND_CHAR;
          r0.ch   = char_code;
          n       = 2'd1;
        end
      end
      cmdsplit_pkg::PH_SKIP,
      cmdsplit_pkg::PH_ARG: begin
        if (is_z && !arg_go) begin
          r0.kind = cmdsplit_pkg::KIND_LINE_END;
          n       = 2'd1;
        end else if (arg_go) begin
          if (is_z) begin
            r0.kind   = cmdsplit_pkg::KIND_ARG_END;
            r0.prefix = run_clip;
            n         = 2'd2;
          end else if (is_b && (ql1 == 2'd0)) begin
            r0.kind   = cmdsplit_pkg::KIND_ARG_END;
            r0.prefix = run_clip;
            n         = 2'd1;
          end else if (is_s) begin
            n = 2'd0;
          end else if (is_q) begin
            if (iqr1) begin
              if (ql2 == cmdsplit_pkg::QUOTE_THIRD) begin
                r0.kind = cmdsplit_pkg::KIND_CHAR;
                r0.ch   = cmdsplit_pkg::CH_QUOTE;
                n       = 2'd1;
              end
            end else if (!run_e[0]) begin
              if (half != '0) begin
                r0.kind   = cmdsplit_pkg::KIND_BSLASH;
                r0.prefix = half_clip;
                n         = 2'd1;
              end
            end else begin
              r0.kind   = cmdsplit_pkg::KIND_CHAR;
              r0.ch     = cmdsplit_pkg::CH_QUOTE;
              r0.prefix = half_clip;
              n         = 2'd1;
            end
          end else begin
            r0.kind   = cmdsplit_pkg::KIND_CHAR;
            r0.ch     = char_code;
            r0.prefix = run_clip;
            n         = 2'd1;
          end
        end
      end
      default: begin
        if (is_z) begin
          r0.kind = cmdsplit_pkg::KIND_LINE_END;
          n       = 2'd1;
        end else if (is_b) begin
          r0.kind = cmdsplit_pkg::KIND_ARG_END;
          n       = 2'd1;
        end else if (!is_q) begin
          r0.kind = cmdsplit_pkg::KIND_CHAR;
          r0.ch   = char_code;
          n       = 2'd1;
        end
      end
    endcase
    r0.last  = (n == 2'd1);
    r1.last  = 1'b1;
    push.cnt = adv ? n : 2'd0;
    push.r0  = r0;
    push.r1  = r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= cmdsplit_pkg::PH_START;
      ql_r    <= 2'd0;
      iqr_r   <= 1'b0;
      run_r   <= '0;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      ql_r    <= ql_nxt;
      iqr_r   <= iqr_nxt;
      run_r   <= run_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/cmdsplit_outq.sv @@
`default_nettype none

module cmdsplit_outq (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire cmdsplit_pkg::push_t                 push,
  input  wire logic                                pop_ready,
  output cmdsplit_pkg::result_t                    head,
  output logic                                     head_valid,
  output logic [cmdsplit_pkg::QLVL_W-1:0]          level
);

  cmdsplit_pkg::result_t                  mem_r [cmdsplit_pkg::QDEPTH];
  logic [cmdsplit_pkg::QPTR_W-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [cmdsplit_pkg::QPTR_W-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [cmdsplit_pkg::QLVL_W-1:0]        level_r, level_nxt;
  logic                                   pop;

  always_comb begin
    head_valid = (level_r != '0);
    head       = mem_r[rd_ptr_r];
    level      = level_r;
    pop        = head_valid && pop_ready;
    wr_ptr_nxt = cmdsplit_pkg::QPTR_W'(wr_ptr_r + push.cnt);
    rd_ptr_nxt = cmdsplit_pkg::QPTR_W'(rd_ptr_r + pop);
    level_nxt  = cmdsplit_pkg::QLVL_W'(level_r + cmdsplit_pkg::QLVL_W'(push.cnt)
                 - cmdsplit_pkg::QLVL_W'(pop));
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem_r[wr_ptr_r] <= push.r0;
    if (push.cnt == 2'd2) mem_r[cmdsplit_pkg::QPTR_W'(wr_ptr_r + 1'b1)] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

endmodule

`default_nettype wire

@@ tb/command_line_argument_splitter_unit_tb.sv @@
`default_nettype none

module command_line_argument_splitter_unit_tb;

  // Random part size, end-of-run drain and the hard stop, all in words or cycles
  localparam int RANDOM_UNITS   = 1850;
  localparam int DRAIN_CYCLES   = 16;
  localparam int TIMEOUT_CYCLES = 4_000_000;
  // Long receiver hold-offs: start once this many words went in, last this long
  localparam int HOLD_AT_1      = 150;
  localparam int HOLD_AT_2      = 1200;
  localparam int HOLD_CYCLES    = 400;

  typedef struct {
    logic [15:0] code;
    bit          steady;  // send back to back, skipping the sender's gaps
  } code_unit_t;

  typedef enum {
    RX_OPEN,
    RX_HALF,
    RX_SPARSE,
    RX_MOSTLY
  } rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] in_char_code = 16'h0000;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [15:0] out_out_char;
  logic [15:0] out_backslash_prefix;
  logic [15:0] out_arg_total;
  logic        out_last_of_run;

  command_line_argument_splitter_unit u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_char_code         (in_char_code),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_kind             (out_kind),
    .out_out_char         (out_out_char),
    .out_backslash_prefix (out_backslash_prefix),
    .out_arg_total        (out_arg_total),
    .out_last_of_run      (out_last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Splitter prediction: own copy of the line state, updated per accepted word
  // ---------------------------------------------------------------------------
  cmdsplit_pkg::phase_t sp_phase  = cmdsplit_pkg::PH_START;
  logic [1:0]           sp_qlvl   = 2'd0;
  logic [15:0]          sp_bslash = 16'd0;
  bit                   sp_qrun   = 1'b0;
  logic [15:0]          sp_args   = 16'd0;

  cmdsplit_pkg::result_t due_results[$];
  code_unit_t            code_units[$];
  int                    mismatches = 0;
  int                    words_in = 0;
  int                    random_units = 0;
  bit                    in_took = 1'b0;

  function automatic bit is_blank(input logic [15:0] c);
    return c == cmdsplit_pkg::CH_SPACE || c == cmdsplit_pkg::CH_TAB;
  endfunction

  // Queue one expected result; the argument count is taken as it stands now
  task automatic due_push(input cmdsplit_pkg::kind_t kind, input logic [15:0] ch,
                          input logic [15:0] prefix);
    cmdsplit_pkg::result_t r;
    r.kind   = kind;
    r.ch     = ch;
    r.prefix = prefix;
    r.total  = sp_args;
    r.last   = 1'b0;
    due_results.push_back(r);
  endtask

  task automatic split_restart();
    sp_phase  = cmdsplit_pkg::PH_START;
    sp_qlvl   = 2'd0;
    sp_bslash = 16'd0;
    sp_qrun   = 1'b0;
    sp_args   = 16'd0;
  endtask

  task automatic count_arg();
    if (sp_args != 16'hFFFF) sp_args++;
  endtask

  // One code unit inside a later argument: quoting, escapes, separators
  task automatic split_in_arg(input logic [15:0] c);
    logic [15:0] half;
    if (sp_qrun && c != cmdsplit_pkg::CH_QUOTE) begin
      sp_qrun = 1'b0;
      if (sp_qlvl == 2'd2) sp_qlvl = 2'd0;
    end
    if (c == cmdsplit_pkg::CH_NUL) begin
      due_push(cmdsplit_pkg::KIND_ARG_END, 16'd0, sp_bslash);
      due_push(cmdsplit_pkg::KIND_LINE_END, 16'd0, 16'd0);
      split_restart();
    end else if (is_blank(c) && sp_qlvl == 2'd0) begin
      due_push(cmdsplit_pkg::KIND_ARG_END, 16'd0, sp_bslash);
      sp_bslash = 16'd0;
      sp_phase  = cmdsplit_pkg::PH_SKIP;
    end else if (c == cmdsplit_pkg::CH_BSLASH) begin
      // saturate at all ones, an odd count
      if (sp_bslash != 16'hFFFF) sp_bslash++;
    end else if (c == cmdsplit_pkg::CH_QUOTE) begin
      if (sp_qrun) begin
        // quotes inside quotes go by thirds
        sp_qlvl++;
        if (sp_qlvl >= cmdsplit_pkg::QUOTE_THIRD) begin
          due_push(cmdsplit_pkg::KIND_CHAR, cmdsplit_pkg::CH_QUOTE, 16'd0);
          sp_qlvl = 2'd0;
        end
      end else begin
        half    = sp_bslash >> 1;
        sp_qrun = 1'b1;
        if (!sp_bslash[0]) begin
          if (half != 16'd0) due_push(cmdsplit_pkg::KIND_BSLASH, 16'd0, half);
          sp_qlvl++;
        end else begin
          due_push(cmdsplit_pkg::KIND_CHAR, cmdsplit_pkg::CH_QUOTE, half);
        end
        sp_bslash = 16'd0;
      end
    end else begin
      due_push(cmdsplit_pkg::KIND_CHAR, c, sp_bslash);
      sp_bslash = 16'd0;
    end
  endtask

  // Predict the results of one accepted word and mark the last of them
  task automatic split_step(input logic [15:0] c);
    int                    base;
    cmdsplit_pkg::result_t r;
    base = due_results.size();
    case (sp_phase)
      cmdsplit_pkg::PH_EXEQ: begin
        if (c == cmdsplit_pkg::CH_NUL) begin
          due_push(cmdsplit_pkg::KIND_ARG_END, 16'd0, 16'd0);
          due_push(cmdsplit_pkg::KIND_LINE_END, 16'd0, 16'd0);
          split_restart();
        end else if (c == cmdsplit_pkg::CH_QUOTE) begin
          due_push(cmdsplit_pkg::KIND_ARG_END, 16'd0, 16'd0);
          sp_phase = cmdsplit_pkg::PH_SKIP;
        end else begin
          due_push(cmdsplit_pkg::KIND_CHAR, c, 16'd0);
        end
      end
      cmdsplit_pkg::PH_EXEP: begin
        if (c == cmdsplit_pkg::CH_NUL) begin
          due_push(cmdsplit_pkg::KIND_ARG_END, 16'd0, 16'd0);
          due_push(cmdsplit_pkg::KIND_LINE_END, 16'd0, 16'd0);
          split_restart();
        end else if (is_blank(c)) begin
          due_push(cmdsplit_pkg::KIND_ARG_END, 16'd0, 16'd0);
          sp_phase = cmdsplit_pkg::PH_SKIP;
        end else begin
          due_push(cmdsplit_pkg::KIND_CHAR, c, 16'd0);
        end
      end
      cmdsplit_pkg::PH_SKIP: begin
        if (c == cmdsplit_pkg::CH_NUL) begin
          due_push(cmdsplit_pkg::KIND_LINE_END, 16'd0, 16'd0);
          split_restart();
        end else if (!is_blank(c)) begin
          count_arg();
          sp_phase  = cmdsplit_pkg::PH_ARG;
          sp_qlvl   = 2'd0;
          sp_qrun   = 1'b0;
          sp_bslash = 16'd0;
          split_in_arg(c);
        end
      end
      cmdsplit_pkg::PH_ARG: split_in_arg(c);
      default: begin
        // start of line: executable path
        if (c == cmdsplit_pkg::CH_NUL) begin
          due_push(cmdsplit_pkg::KIND_LINE_END, 16'd0, 16'd0);
          split_restart();
        end else begin
          count_arg();
          if (c == cmdsplit_pkg::CH_QUOTE) begin
            sp_phase = cmdsplit_pkg::PH_EXEQ;
          end else if (is_blank(c)) begin
            due_push(cmdsplit_pkg::KIND_ARG_END, 16'd0, 16'd0);
            sp_phase = cmdsplit_pkg::PH_SKIP;
          end else begin
            due_push(cmdsplit_pkg::KIND_CHAR, c, 16'd0);
            sp_phase = cmdsplit_pkg::PH_EXEP;
          end
        end
      end
    endcase
    if (due_results.size() > base) begin
      r = due_results[due_results.size() - 1];
      r.last = 1'b1;
      due_results[due_results.size() - 1] = r;
    end
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t: mismatch: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic put(input logic [15:0] c, input bit steady);
    code_unit_t u;
    u.code   = c;
    u.steady = steady;
    code_units.push_back(u);
  endtask

  // Weighted toward the characters the splitter reacts to
  function automatic logic [15:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 22) return cmdsplit_pkg::CH_QUOTE;
    if (r < 42) return cmdsplit_pkg::CH_BSLASH;
    if (r < 56) return cmdsplit_pkg::CH_SPACE;
    if (r < 62) return cmdsplit_pkg::CH_TAB;
    if (r < 85) return 16'h0061 + 16'($urandom_range(0, 25));
    return 16'($urandom_range(1, 65535));
  endfunction

  // Mostly well-formed lines with random content; some raw noise with stray ends
  task automatic put_random_line();
    int          len;
    int          sel;
    logic [15:0] c;
    len = $urandom_range(0, 18);
    sel = $urandom_range(0, 19);
    if (sel == 0) begin
      for (int i = 0; i < len; i++) begin
        c = ($urandom_range(0, 3) == 0) ? cmdsplit_pkg::CH_NUL
                                        : 16'($urandom_range(0, 65535));
        put(c, 1'b0);
      end
      random_units += len;
    end else begin
      if (len != 0) begin
        // open the executable path with a quote or a blank now and then
        if (sel < 6) c = cmdsplit_pkg::CH_QUOTE;
        else if (sel == 6) c = cmdsplit_pkg::CH_TAB;
        else if (sel == 7) c = cmdsplit_pkg::CH_SPACE;
        else c = pick_char();
        put(c, 1'b0);
        for (int i = 1; i < len; i++) put(pick_char(), 1'b0);
      end
      put(cmdsplit_pkg::CH_NUL, 1'b0);
      random_units += len + 1;
    end
  endtask

  // Directed lines: empty line, blank-first path, quoted path, both path ends,
  // even/odd backslashes before a quote, quote thirds, trailing backslashes
  logic [15:0] directed_units[$] = '{
    cmdsplit_pkg::CH_NUL,
    cmdsplit_pkg::CH_TAB, cmdsplit_pkg::CH_NUL,
    cmdsplit_pkg::CH_QUOTE, 16'hFFFF, cmdsplit_pkg::CH_SPACE, cmdsplit_pkg::CH_QUOTE,
    16'h8000, cmdsplit_pkg::CH_NUL,
    16'h0078, cmdsplit_pkg::CH_NUL,
    cmdsplit_pkg::CH_SPACE, cmdsplit_pkg::CH_BSLASH, cmdsplit_pkg::CH_BSLASH,
    cmdsplit_pkg::CH_QUOTE, cmdsplit_pkg::CH_QUOTE, cmdsplit_pkg::CH_QUOTE,
    cmdsplit_pkg::CH_QUOTE,
    cmdsplit_pkg::CH_BSLASH, cmdsplit_pkg::CH_BSLASH, cmdsplit_pkg::CH_BSLASH,
    cmdsplit_pkg::CH_QUOTE, cmdsplit_pkg::CH_TAB, cmdsplit_pkg::CH_QUOTE, 16'h0001,
    cmdsplit_pkg::CH_NUL,
    16'h0061, cmdsplit_pkg::CH_TAB, cmdsplit_pkg::CH_QUOTE, cmdsplit_pkg::CH_QUOTE,
    16'h0062, cmdsplit_pkg::CH_BSLASH, cmdsplit_pkg::CH_NUL
  };

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length with random gaps, steady words back to back
  // ---------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left = 0;

  always @(negedge clk) begin
    code_unit_t u;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (code_units.size() != 0) begin
        u = code_units.pop_front();
        in_valid     <= 1'b1;
        in_char_code <= u.code;
        if (!u.steady) begin
          burst_left--;
          if (burst_left <= 0) begin
            // one burst in eight runs long with no idling at all
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                       : $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern changes every window; two long hold-offs fill the
  // result queue so the block has to drop in_ready while words keep coming
  // ---------------------------------------------------------------------------
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_window = 0;
  int       hold_left = 0;
  int       holds_done = 0;

  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if ((holds_done == 0 && words_in >= HOLD_AT_1) ||
                 (holds_done == 1 && words_in >= HOLD_AT_2)) begin
      holds_done++;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      if (rx_window == 0) begin
        rx_window = $urandom_range(50, 300);
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
      end
      rx_window--;
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_HALF:   out_ready <= $urandom_range(0, 1) == 1;
        RX_SPARSE: out_ready <= $urandom_range(0, 3) == 0;
        default:   out_ready <= $urandom_range(0, 7) != 0;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on every accepted input word, check every result word
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cmdsplit_pkg::result_t want;
    in_took <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      split_step(in_char_code);
      words_in++;
    end
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("unexpected word kind=%0d char=%h prefix=%0d total=%0d",
                                  out_kind, out_out_char, out_backslash_prefix,
                                  out_arg_total));
      end else begin
        want = due_results.pop_front();
        if (out_kind !== want.kind || out_out_char !== want.ch ||
            out_backslash_prefix !== want.prefix || out_arg_total !== want.total ||
            out_last_of_run !== want.last) begin
          report_mismatch($sformatf(
            "got kind=%0d char=%h prefix=%0d total=%0d last=%b, want %0d %h %0d %0d %b",
            out_kind, out_out_char, out_backslash_prefix, out_arg_total, out_last_of_run,
            want.kind, want.ch, want.prefix, want.total, want.last));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: fill the word queue, release reset, wait for the drain
  // ---------------------------------------------------------------------------
  initial begin
    foreach (directed_units[i]) put(directed_units[i], 1'b0);
    while (random_units < RANDOM_UNITS) put_random_line();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (code_units.size() != 0 || in_valid) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    // hold a little longer so a stray extra word still gets caught
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hard stop in case the handshake hangs
  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
rtl/cmdsplit_pkg.sv
rtl/cmdsplit_core.sv
rtl/cmdsplit_outq.sv
rtl/command_line_argument_splitter_unit.sv
tb/command_line_argument_splitter_unit_tb.sv
